// ===== design/sup_pkg.sv =====
// ----------------------------------------------------------------------------
// sup_pkg
// Shared types and constants for the SOCKS5 UDP header parser.
// ----------------------------------------------------------------------------
package sup_pkg;

   // Configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVER_NAME_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVER_NAME_FIRST  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVER_NAME_SECOND = 2'd2;

   // Verdict codes
   localparam logic [1:0] VERDICT_OK          = 2'd0;
   localparam logic [1:0] VERDICT_INVALID     = 2'd1;
   localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd2;

   // Address type codes from the header
   localparam logic [7:0] ATYP_V4   = 8'd1;
   localparam logic [7:0] ATYP_NAME = 8'd3;
   localparam logic [7:0] ATYP_V6   = 8'd4;

   localparam logic [7:0] V4_ADDR_BYTES = 8'd4;
   localparam logic [7:0] V6_ADDR_BYTES = 8'd16;
   localparam int unsigned NAME_SLOTS   = 16;

   // Result queue between the parser and the output stage
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QUEUE_PTR_WIDTH = 2;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_PAYLOAD,
      PHASE_DROP
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic        res_kind;
      logic [1:0]  verdict;
      logic        target_kind;
      logic        addr_family;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [15:0] dest_port;
      logic [7:0]  payload_byte;
      logic        res_last;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/sup_front.sv =====
// ----------------------------------------------------------------------------
// sup_front
// Header parser: takes one datagram byte per cycle while the result queue is not
// full, tracks the header fields and pushes verdicts and payload bytes into that queue.
// ----------------------------------------------------------------------------
module sup_front import sup_pkg::*; #(
   parameter int unsigned MAX_SERVER_NAME = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   input  req_type                    req_data,
   output logic                       req_stall,
   input  queue_status_type           q_stat,
   output logic                       push,
   output rsp_type                    push_data
);

   logic [4:0]  name_len_ff;
   logic [63:0] name_first_ff;
   logic [63:0] name_second_ff;

   phase_type   phase_ff, phase_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  atype_ff, atype_in;
   logic [7:0]  len_ff, len_in;
   logic [63:0] shift_hi_ff, shift_hi_in;
   logic [63:0] shift_lo_ff, shift_lo_in;
   logic [15:0] port_ff, port_in;
   logic        nm_ff, nm_in;
   logic [1:0]  pend_ff, pend_in;

   logic        accept;
   logic [7:0]  b;
   logic        is_name;
   logic [9:0]  base;
   logic [9:0]  addr_end;
   logic [9:0]  pos_ext;
   logic [8:0]  name_idx;
   logic [63:0] sel_word;
   logic [7:0]  srv_byte;
   logic        name_ok;
   logic [15:0] port_new;
   logic        server;
   logic        finish_ok;
   logic [1:0]  finish_code;
   logic        v4_mapped;
   logic        hdr_fail;
   logic        hdr_done;
   logic [1:0]  fail_code;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign b         = req_data.in_byte;

   assign is_name  = (atype_ff == ATYP_NAME);
   assign base     = is_name ? 10'd5 : 10'd4;
   assign addr_end = base + {2'b00, len_ff};
   assign pos_ext  = {1'b0, pos_ff};
   assign name_idx = pos_ff - base[8:0];
   assign sel_word = name_idx[3] ? name_second_ff : name_first_ff;
   assign srv_byte = sel_word[{3'd7 - name_idx[2:0], 3'b000} +: 8];
   assign name_ok  = (name_idx < 9'(NAME_SLOTS)) && (name_idx < 9'(MAX_SERVER_NAME))
                     && (srv_byte == b);
   assign port_new = {port_ff[7:0], b};

   // A name target is the tunnel server when empty or equal to the configured name.
   assign server = (len_ff == 8'd0) ||
                   (nm_ff && (name_len_ff <= 5'(MAX_SERVER_NAME)) &&
                    (len_ff == {3'b000, name_len_ff}));
   assign finish_ok   = (port_new != 16'd0) && (!is_name || server);
   assign finish_code = (port_new == 16'd0) ? VERDICT_INVALID : VERDICT_UNSUPPORTED;
   assign v4_mapped   = (shift_hi_ff == 64'd0) && (shift_lo_ff[63:32] == 32'h0000_FFFF);

   // Header field tracking.
   always_comb begin
      pos_in      = pos_ff;
      atype_in    = atype_ff;
      len_in      = len_ff;
      shift_hi_in = shift_hi_ff;
      shift_lo_in = shift_lo_ff;
      port_in     = port_ff;
      nm_in       = nm_ff;
      pend_in     = pend_ff;
      hdr_fail    = 1'b0;
      hdr_done    = 1'b0;
      fail_code   = VERDICT_INVALID;
      if (accept && phase_ff == PHASE_HEADER) begin
         pos_in = pos_ff + 9'd1;
         if (pos_ff < 9'd2) begin
            if (b != 8'd0) begin
               pend_in = VERDICT_INVALID;
            end
         end else if (pos_ff == 9'd2) begin
            if (b != 8'd0 && pend_ff == VERDICT_OK) begin
               pend_in = VERDICT_UNSUPPORTED;
            end
         end else if (pos_ff == 9'd3) begin
            atype_in = b;
            if (pend_ff != VERDICT_OK) begin
               hdr_fail  = 1'b1;
               fail_code = pend_ff;
            end else begin
               case (b)
                  ATYP_V4: begin
                     len_in = V4_ADDR_BYTES;
                  end
                  ATYP_V6: begin
                     len_in = V6_ADDR_BYTES;
                  end
                  ATYP_NAME: begin
                  end
                  default: begin
                     hdr_fail  = 1'b1;
                     fail_code = VERDICT_UNSUPPORTED;
                  end
               endcase
            end
         end else if (is_name && pos_ff == 9'd4) begin
            len_in = b;
         end else if (pos_ext < addr_end) begin
            if (is_name) begin
               if (!name_ok) begin
                  nm_in = 1'b0;
               end
            end else begin
               shift_hi_in = {shift_hi_ff[55:0], shift_lo_ff[63:56]};
               shift_lo_in = {shift_lo_ff[55:0], b};
            end
         end else begin
            port_in = port_new;
            if (pos_ext == addr_end + 10'd1) begin
               hdr_done = 1'b1;
            end
         end
         // The datagram ended before the header was complete.
         if (req_data.in_last && !hdr_fail && !hdr_done) begin
            hdr_fail  = 1'b1;
            fail_code = VERDICT_INVALID;
         end
      end
      if (accept && req_data.in_last) begin
         pos_in      = 9'd0;
         atype_in    = 8'd0;
         len_in      = 8'd0;
         shift_hi_in = 64'd0;
         shift_lo_in = 64'd0;
         port_in     = 16'd0;
         nm_in       = 1'b1;
         pend_in     = VERDICT_OK;
      end
   end

   // Packet phase next state.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_data.in_last) begin
            phase_in = PHASE_HEADER;
         end else if (phase_ff == PHASE_HEADER) begin
            if (hdr_fail) begin
               phase_in = PHASE_DROP;
            end else if (hdr_done) begin
               phase_in = finish_ok ? PHASE_PAYLOAD : PHASE_DROP;
            end
         end
      end
   end

   // Result item for the queue.
   always_comb begin
      push      = accept && (phase_ff == PHASE_PAYLOAD || hdr_fail || hdr_done);
      push_data = '0;
      push_data.res_last = req_data.in_last;
      if (phase_ff == PHASE_PAYLOAD) begin
         push_data.res_kind     = 1'b1;
         push_data.payload_byte = b;
      end else if (hdr_fail) begin
         push_data.verdict = fail_code;
      end else if (hdr_done) begin
         if (!finish_ok) begin
            push_data.verdict = finish_code;
         end else begin
            push_data.verdict   = VERDICT_OK;
            push_data.dest_port = port_new;
            if (is_name) begin
               push_data.target_kind = 1'b1;
            end else if (atype_ff == ATYP_V4 || v4_mapped) begin
               push_data.addr_lower = {32'd0, shift_lo_ff[31:0]};
            end else begin
               push_data.addr_family = 1'b1;
               push_data.addr_upper  = shift_hi_ff;
               push_data.addr_lower  = shift_lo_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_len_ff    <= 5'd0;
         name_first_ff  <= 64'd0;
         name_second_ff <= 64'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SERVER_NAME_LENGTH: begin
               name_len_ff <= csr_wdata[4:0];
            end
            CSR_SERVER_NAME_FIRST: begin
               name_first_ff <= csr_wdata;
            end
            CSR_SERVER_NAME_SECOND: begin
               name_second_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HEADER;
         pos_ff      <= 9'd0;
         atype_ff    <= 8'd0;
         len_ff      <= 8'd0;
         shift_hi_ff <= 64'd0;
         shift_lo_ff <= 64'd0;
         port_ff     <= 16'd0;
         nm_ff       <= 1'b1;
         pend_ff     <= VERDICT_OK;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         atype_ff    <= atype_in;
         len_ff      <= len_in;
         shift_hi_ff <= shift_hi_in;
         shift_lo_ff <= shift_lo_in;
         port_ff     <= port_in;
         nm_ff       <= nm_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

// ===== design/sup_queue.sv =====
// ----------------------------------------------------------------------------
// sup_queue
// Short result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module sup_queue import sup_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsp_type          push_data,
   input  logic             pop,
   output rsp_type          head,
   output queue_status_type q_stat
);

   rsp_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;

   assign q_stat.full  = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/sup_back.sv =====
// ----------------------------------------------------------------------------
// sup_back
// Output stage: moves queued results into the result register and holds
// them while the receiver stalls.
// ----------------------------------------------------------------------------
module sup_back import sup_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  rsp_type          head,
   output logic             pop,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             rsp_stall
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // The register is refilled when empty or when its result transfers this cycle.
   assign pop       = !q_stat.empty && (!valid_ff || !rsp_stall);
   assign valid_in  = pop || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== design/socks5_udp_header_parser.sv =====
// ----------------------------------------------------------------------------
// socks5_udp_header_parser
// Parses the SOCKS5 UDP request header of each datagram and forwards payload.
// ----------------------------------------------------------------------------
// One datagram byte is taken per cycle, and a byte can follow in every cycle.
// The parser gives one verdict per datagram (when the header is complete,
// when it fails, or on the final byte of a short datagram) and then passes
// payload bytes through after an ok verdict. A result is written into a
// four-entry result queue at the edge that accepts its byte, and from
// there it moves into the output register, from which it transfers on rsp.
// The input stalls only while that queue is full, which happens when the
// result side stalls.
module socks5_udp_header_parser import sup_pkg::*; #(
   parameter int unsigned MAX_SERVER_NAME = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   input  req_type                    req_data,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  logic                       rsp_stall
);

   queue_status_type q_stat;
   logic             push;
   rsp_type          push_data;
   logic             pop;
   rsp_type          head;

   sup_front #(
      .MAX_SERVER_NAME(MAX_SERVER_NAME)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   sup_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   sup_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ===== tb/parse_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// parse_scoreboard_pkg
// Expected-result tracking for the SOCKS5 UDP header parser: a byte-level
// header predictor with its own copy of the server name registers, and a
// field-by-field check of every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
package parse_scoreboard_pkg;
   import sup_pkg::*;

   localparam int unsigned SERVER_NAME_MAX = 16;
   localparam int unsigned REPORT_LINES    = 40;

   localparam logic KIND_VERDICT  = 1'b0;
   localparam logic KIND_PAYLOAD  = 1'b1;
   localparam logic TARGET_SERVER = 1'b1;
   localparam logic FAMILY_V6     = 1'b1;

   // Byte offsets within the header.
   localparam int unsigned POS_FRAG      = 2;
   localparam int unsigned POS_ATYP      = 3;
   localparam int unsigned POS_NAME_LEN  = 4;
   localparam int unsigned ADDR_BASE     = 4;
   localparam int unsigned NAME_BASE     = 5;

   class header_parse_scoreboard;
      logic [4:0]  name_length;
      logic [63:0] name_first;
      logic [63:0] name_second;

      logic [8:0]  position;
      logic [7:0]  addr_type;
      logic [7:0]  addr_length;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [15:0] port_bits;
      logic        name_ok;
      logic [1:0]  held_error;
      phase_type   phase;

      rsp_type     expected_parse_results[$];
      int unsigned mismatches;

      function new();
         name_length = '0;
         name_first  = '0;
         name_second = '0;
         mismatches  = 0;
         clear_datagram();
      endfunction

      function void clear_datagram();
         position    = '0;
         addr_type   = '0;
         addr_length = '0;
         addr_high   = '0;
         addr_low    = '0;
         port_bits   = '0;
         name_ok     = 1'b1;
         held_error  = VERDICT_OK;
         phase       = PHASE_HEADER;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [63:0] value);
         case (index)
            CSR_SERVER_NAME_LENGTH: name_length = value[4:0];
            CSR_SERVER_NAME_FIRST:  name_first  = value;
            CSR_SERVER_NAME_SECOND: name_second = value;
            default: ;
         endcase
      endfunction

      function logic [7:0] server_byte(int unsigned index);
         logic [63:0] word;
         word = (index < 8) ? name_first : name_second;
         return word[63 - 8*(index % 8) -: 8];
      endfunction

      function void reject(logic [1:0] verdict, logic last);
         rsp_type r;
         r = '0;
         r.res_kind = KIND_VERDICT;
         r.verdict  = verdict;
         r.res_last = last;
         expected_parse_results.push_back(r);
         phase = PHASE_DROP;
      endfunction

      function void complete_header(logic last);
         rsp_type r;
         // A zero port fails before the address is looked at.
         if (port_bits == 16'h0) begin
            reject(VERDICT_INVALID, last);
            return;
         end
         r = '0;
         r.res_kind  = KIND_VERDICT;
         r.verdict   = VERDICT_OK;
         r.dest_port = port_bits;
         r.res_last  = last;
         if (addr_type == ATYP_NAME) begin
            if (!(addr_length == 0 || (name_ok && name_length <= SERVER_NAME_MAX &&
                                       addr_length == name_length))) begin
               reject(VERDICT_UNSUPPORTED, last);
               return;
            end
            r.target_kind = TARGET_SERVER;
         end else if (addr_type == ATYP_V4) begin
            r.addr_lower = {32'h0, addr_low[31:0]};
         end else if (addr_high == 64'h0 && addr_low[63:32] == 32'h0000_FFFF) begin
            // An IPv4-mapped IPv6 address is reported as plain IPv4.
            r.addr_lower = {32'h0, addr_low[31:0]};
         end else begin
            r.addr_family = FAMILY_V6;
            r.addr_upper  = addr_high;
            r.addr_lower  = addr_low;
         end
         expected_parse_results.push_back(r);
         phase = PHASE_PAYLOAD;
      endfunction

      function void parse_header_byte(logic [7:0] value, logic last);
         int unsigned p;
         int unsigned base;
         int unsigned stop;
         p = position;
         position = position + 9'd1;
         if (p < POS_FRAG) begin
            if (value != 8'h0) held_error = VERDICT_INVALID;
         end else if (p == POS_FRAG) begin
            if (value != 8'h0 && held_error == VERDICT_OK) held_error = VERDICT_UNSUPPORTED;
         end else if (p == POS_ATYP) begin
            addr_type = value;
            if (held_error != VERDICT_OK) begin
               reject(held_error, last);
               return;
            end
            if (value == ATYP_V4) addr_length = V4_ADDR_BYTES;
            else if (value == ATYP_V6) addr_length = V6_ADDR_BYTES;
            else if (value != ATYP_NAME) begin
               reject(VERDICT_UNSUPPORTED, last);
               return;
            end
         end else if (addr_type == ATYP_NAME && p == POS_NAME_LEN) begin
            addr_length = value;
         end else begin
            base = (addr_type == ATYP_NAME) ? NAME_BASE : ADDR_BASE;
            stop = base + addr_length;
            if (p < stop) begin
               if (addr_type == ATYP_NAME) begin
                  if (p - base >= SERVER_NAME_MAX || server_byte(p - base) != value)
                     name_ok = 1'b0;
               end else begin
                  addr_high = {addr_high[55:0], addr_low[63:56]};
                  addr_low  = {addr_low[55:0], value};
               end
            end else begin
               port_bits = {port_bits[7:0], value};
               if (p == stop + 1) begin
                  complete_header(last);
                  return;
               end
            end
         end
         if (last) reject(VERDICT_INVALID, last);
      endfunction

      // Called for every accepted input transfer.
      function void parse_byte(req_type item);
         rsp_type r;
         if (phase == PHASE_PAYLOAD) begin
            r = '0;
            r.res_kind     = KIND_PAYLOAD;
            r.payload_byte = item.in_byte;
            r.res_last     = item.in_last;
            expected_parse_results.push_back(r);
         end else if (phase == PHASE_HEADER) begin
            parse_header_byte(item.in_byte, item.in_last);
         end
         if (item.in_last) clear_datagram();
      endfunction

      task report(string msg);
         if (mismatches < REPORT_LINES) $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string field, logic [63:0] got, logic [63:0] want);
         if (got !== want) report($sformatf("%s is %h, expected %h", field, got, want));
      endtask

      // Called for every accepted result transfer.
      task check_result(rsp_type got);
         rsp_type want;
         if (expected_parse_results.size() == 0) begin
            report($sformatf("result %h arrived with nothing outstanding", got));
            return;
         end
         want = expected_parse_results.pop_front();
         compare_field("res_kind", got.res_kind, want.res_kind);
         compare_field("verdict", got.verdict, want.verdict);
         compare_field("target_kind", got.target_kind, want.target_kind);
         compare_field("addr_family", got.addr_family, want.addr_family);
         compare_field("addr_upper", got.addr_upper, want.addr_upper);
         compare_field("addr_lower", got.addr_lower, want.addr_lower);
         compare_field("dest_port", got.dest_port, want.dest_port);
         compare_field("payload_byte", got.payload_byte, want.payload_byte);
         compare_field("res_last", got.res_last, want.res_last);
      endtask
   endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Datagram-level test of the SOCKS5 UDP header parser. Hand-built headers
// cover each verdict and address form, then random datagrams (mostly well
// formed, some truncated, corrupted or pure noise) run under several server
// name settings with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sup_pkg::*;
   import parse_scoreboard_pkg::*;

   localparam int unsigned IDLE_PERCENT  = 26;
   localparam int unsigned RANDOM_BYTES  = 1750;
   localparam int unsigned PHASE_BYTES   = RANDOM_BYTES / 6;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_LIMIT    = 2000;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                       req_valid = 1'b0;
   req_type                    req_data  = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       rsp_stall = 1'b0;

   bit                         steady = 1'b0;
   int unsigned                quiet_cycles = 0;
   header_parse_scoreboard     board;
   logic [7:0]                 datagram[$];

   socks5_udp_header_parser #(
      .MAX_SERVER_NAME(SERVER_NAME_MAX)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_data(req_data),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_stall(rsp_stall)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Transfers are sampled at the edge, before any of this step's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.parse_byte(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= HOLD_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: value, in_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_datagram();
      for (int i = 0; i < datagram.size(); i++) send_byte(datagram[i], i == datagram.size() - 1);
      datagram.delete();
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      while (board.expected_parse_results.size() != 0) @(posedge clock);
      // Header bytes give no result, so the parser may still be busy briefly.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_register(index, value);
   endtask

   task automatic set_server_name(input logic [4:0] length, input logic [63:0] first,
                                  input logic [63:0] second);
      await_results();
      write_register(CSR_SERVER_NAME_LENGTH, CSR_DATA_WIDTH'(length));
      write_register(CSR_SERVER_NAME_FIRST, first);
      write_register(CSR_SERVER_NAME_SECOND, second);
   endtask

   // Appends count bytes of value, most significant first.
   function automatic void put_bytes(input logic [127:0] value, input int unsigned count);
      for (int i = int'(count) - 1; i >= 0; i--) datagram.push_back(value[8*i +: 8]);
   endfunction

   function automatic void put_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) datagram.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void put_server_name(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         datagram.push_back(i < SERVER_NAME_MAX ? board.server_byte(i) : 8'($urandom_range(255)));
   endfunction

   function automatic void build_wellformed();
      int unsigned form;
      logic [7:0]  length;
      form = $urandom_range(5);
      put_bytes(24'h0, 3);
      case (form)
         0: begin
            datagram.push_back(ATYP_V4);
            put_random(4);
         end
         1: begin
            datagram.push_back(ATYP_V6);
            put_random(16);
         end
         2: begin
            datagram.push_back(ATYP_V6);
            put_bytes(96'h0000_0000_0000_0000_0000_FFFF, 12);
            put_random(4);
         end
         3: begin
            datagram.push_back(ATYP_NAME);
            datagram.push_back({3'b000, board.name_length});
            put_server_name(board.name_length);
         end
         4: begin
            datagram.push_back(ATYP_NAME);
            datagram.push_back(8'h00);
         end
         default: begin
            // Long names are kept rare since every name byte costs a cycle.
            length = ($urandom_range(39) == 0) ? 8'($urandom_range(255, 21))
                                               : 8'($urandom_range(20, 1));
            datagram.push_back(ATYP_NAME);
            datagram.push_back(length);
            if ($urandom_range(1) == 1) put_server_name(length);
            else put_random(length);
         end
      endcase
      if ($urandom_range(15) == 0) put_bytes(16'h0, 2);
      else put_random(2);
      put_random($urandom_range(12));
   endfunction

   function automatic void build_random_datagram();
      int unsigned pick;
      int unsigned cut;
      pick = $urandom_range(99);
      build_wellformed();
      if (pick >= 70 && pick < 80) begin
         cut = $urandom_range(datagram.size() - 1, 1);
         while (datagram.size() > cut) void'(datagram.pop_back());
      end else if (pick >= 80 && pick < 90) begin
         datagram[$urandom_range(3)] = 8'($urandom_range(255));
      end else if (pick >= 90) begin
         datagram.delete();
         put_random($urandom_range(24, 1));
      end
   endfunction

   task automatic run_phase(input logic [4:0] length, input logic [63:0] first,
                            input logic [63:0] second);
      int unsigned sent;
      set_server_name(length, first, second);
      sent = 0;
      while (sent < PHASE_BYTES) begin
         build_random_datagram();
         sent += datagram.size();
         send_datagram();
      end
   endtask

   task automatic run_directed();
      // IPv4 target with payload
      put_bytes(32'h0000_0001, 4); put_bytes(32'hC0A8_0102, 4);
      put_bytes(16'h01BB, 2); put_bytes(16'hFF00, 2); send_datagram();
      // Full IPv6 target, all ones
      put_bytes(32'h0000_0004, 4); put_bytes({128{1'b1}}, 16);
      put_bytes(16'hFFFF, 2); put_bytes(8'h5A, 1); send_datagram();
      // IPv4-mapped IPv6 folds to IPv4
      put_bytes(32'h0000_0004, 4);
      put_bytes(128'h0000_0000_0000_0000_0000_FFFF_0A00_0001, 16);
      put_bytes(16'h0035, 2); send_datagram();
      // Empty name means the server
      put_bytes(40'h00_0000_0300, 5); put_bytes(24'h1234_A5, 3); send_datagram();
      // Configured server name
      put_bytes(40'h00_0000_0310, 5); put_server_name(16);
      put_bytes(24'h0001_7E, 3); send_datagram();
      // Server name prefix with a byte past the name limit
      put_bytes(40'h00_0000_0311, 5); put_server_name(17);
      put_bytes(16'h0101, 2); send_datagram();
      // Other name, trailing bytes dropped
      put_bytes(40'h00_0000_0303, 5); put_bytes(24'h616263, 3);
      put_bytes(32'h0050_1122, 4); send_datagram();
      // Nonzero reserved byte
      put_bytes(32'h0100_0001, 4); put_bytes(48'h0102_0304_0050, 6); send_datagram();
      // Reserved and fragment both set, reserved wins
      put_bytes(32'h0080_FF01, 4); send_datagram();
      // Fragment set
      put_bytes(32'h0000_0101, 4); put_bytes(48'h0102_0304_0050, 6); send_datagram();
      // Unknown address types
      put_bytes(32'h0000_0002, 4); send_datagram();
      put_bytes(32'h0000_00FF, 4); send_datagram();
      put_bytes(40'h00_0000_0012, 5); send_datagram();
      // Short datagrams
      put_bytes(40'h00_0000_01C0, 5); send_datagram();
      put_bytes(8'h00, 1); send_datagram();
      put_bytes(24'h00_0005, 3); send_datagram();
      put_bytes(72'h00_0000_0101_0203_0412, 9); send_datagram();
      // Zero port, with an address and with a foreign name
      put_bytes(32'h0000_0001, 4); put_bytes(48'h0102_0304_0000, 6); send_datagram();
      put_bytes(64'h0000_0003_0178_0000, 8); send_datagram();
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_server_name(5'd16, 64'h7365_7276_6572_2E74, 64'h756E_6E65_6C2E_6C6E);
      run_directed();
      run_phase(5'd0, 64'h0, 64'h0);
      run_phase(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
      steady <= 1'b1;
      run_phase(5'($urandom_range(15, 1)), {$urandom, $urandom}, {$urandom, $urandom});
      steady <= 1'b0;
      run_phase(5'd31, {64{1'b1}}, {64{1'b1}});
      run_phase(5'd17, {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(5'd8, {$urandom, $urandom}, {$urandom, $urandom});
      await_results();
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
